// ----- src/binary_descriptor_k_majority_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for binary descriptor k-majority clustering
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef BINARY_DESCRIPTOR_K_MAJORITY_MACROS_SVH
`define BINARY_DESCRIPTOR_K_MAJORITY_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define BDKM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define BDKM_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define BDKM_ASSERT(lbl, clk, rstn, prop)
`define BDKM_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- src/bdkm_pkg.sv -----
// ----------------------------------------------------------------------------
// bdkm_pkg
// Shared types, codes and helpers for the k-majority clustering block.
// ----------------------------------------------------------------------------
package bdkm_pkg;

  localparam int unsigned WORD_BITS = 64;

  typedef enum logic [1:0] {
    OP_LOAD_CENTER = 2'd0,
    OP_LOAD_DESC   = 2'd1,
    OP_RUN         = 2'd2,
    OP_NONE        = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_POINT_COUNT   = 2'd0,
    REG_CLUSTER_COUNT = 2'd1,
    REG_ITER_LIMIT    = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ASSIGN,
    ST_ADRAIN,
    ST_VOTE,
    ST_VDRAIN,
    ST_UPDATE,
    ST_EMIT
  } st_e;

  // Control part of a beat travelling down the cell chain.
  typedef struct packed {
    logic vld;
    logic vote;
    logic last;
  } beat_ctl_t;

  // Commands from the sequencer to every cell.
  typedef struct packed {
    logic clr;
    logic upd;
  } cell_cmd_t;

  function automatic logic [6:0] popcnt64(input logic [WORD_BITS-1:0] x);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      n = n + 7'(x[i]);
    end
    return n;
  endfunction

endpackage

// ----- src/binary_descriptor_k_majority.sv -----
// ----------------------------------------------------------------------------
// binary_descriptor_k_majority
// K-majority clustering of binary descriptors by Hamming distance.
// ----------------------------------------------------------------------------
// Usage. Input beats on the s_axis channel carry an opcode in tuser: load a
// center word, load a descriptor word, or run. Load beats are taken one per
// cycle and produce no output. A run beat starts the clustering; the input
// channel then stays not ready until the last center word has been handed
// to the output register. Registers are written on the cfg channel, which is
// always ready, and must only be written while the block is idle.
// Rounds. One round takes two passes through the descriptor memory, one
// word per cycle (RW = DESC_BYTES/8 words per point), each followed by a
// drain through the cell chain, plus an update step. The memory read port,
// one word per cycle, sets the pace of each pass.
// Output. k*RW center words follow, one per cycle when m_axis_tready is
// high; a stalled receiver simply holds the output register and the block.
// Reset clears control state and the registers to their defaults; the
// descriptor and center stores hold garbage until loaded.
// ----------------------------------------------------------------------------
`include "binary_descriptor_k_majority_macros.svh"

module binary_descriptor_k_majority
  import bdkm_pkg::*;
#(
  parameter int unsigned MAX_POINTS   = 1024,
  parameter int unsigned MAX_CLUSTERS = 16,
  parameter int unsigned DESC_BYTES   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: row_index[9:0], word_index[11:10], word_value[75:12], zero pad
  input  logic [79:0] s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: center_index[3:0], center_word_index[5:4], center_word[69:6],
  //        rounds_used[77:70], zero pad
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // Register write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  localparam int unsigned RW    = DESC_BYTES / 8;
  localparam int unsigned WIW   = (RW > 1) ? $clog2(RW) : 1;
  localparam int unsigned PW    = $clog2(MAX_POINTS);
  localparam int unsigned CNTW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned KW    = $clog2(MAX_CLUSTERS);
  localparam int unsigned KCW   = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned DW    = $clog2(RW * WORD_BITS + 1);
  localparam int unsigned AW    = PW + WIW;
  localparam int unsigned DRAIN = MAX_CLUSTERS + 2;
  localparam int unsigned DRW   = $clog2(DRAIN + 1);

  // Input field decode.
  logic [1:0]           in_op;
  logic [9:0]           in_row;
  logic [1:0]           in_word;
  logic [WORD_BITS-1:0] in_value;
  logic                 in_acc, word_ok;

  assign in_op    = s_axis_tuser;
  assign in_row   = s_axis_tdata[9:0];
  assign in_word  = s_axis_tdata[11:10];
  assign in_value = s_axis_tdata[75:12];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign word_ok  = 32'(in_word) < RW;

  // Configuration registers.
  logic [10:0] pcount_q;
  logic [4:0]  ccount_q;
  logic [7:0]  limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= 11'd1024;
      ccount_q <= 5'd16;
      limit_q  <= 8'd20;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_e'(cfg_index_i))
        REG_POINT_COUNT:   pcount_q <= cfg_data_i;
        REG_CLUSTER_COUNT: ccount_q <= cfg_data_i[4:0];
        REG_ITER_LIMIT:    limit_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Effective point and cluster counts after saturation.
  logic [CNTW-1:0] n_pts;
  logic [KCW-1:0]  k_cl;

  assign n_pts = (32'(pcount_q) > MAX_POINTS) ? CNTW'(MAX_POINTS) : CNTW'(pcount_q);
  assign k_cl  = (ccount_q == '0) ? KCW'(1) :
                 (32'(ccount_q) > MAX_CLUSTERS) ? KCW'(MAX_CLUSTERS) : KCW'(ccount_q);

  // Sequencer state.
  st_e              state_q, state_d;
  logic [CNTW-1:0]  pt_q;
  logic [WIW-1:0]   wd_q;
  logic [DRW-1:0]   drn_q;
  logic [7:0]       round_q;
  logic [PW-1:0]    lab_ptr_q;
  logic [KW-1:0]    ec_q;
  logic [WIW-1:0]   ew_q;
  logic             issue, issue_last, wd_last, drained, any_chg;
  logic             run_start, out_load, emit_last, lab_we;
  cell_cmd_t        cmd;

  assign wd_last    = wd_q == WIW'(RW - 1);
  assign issue_last = (pt_q == n_pts - 1'b1) && wd_last;
  assign drained    = drn_q == DRW'(DRAIN - 1);
  assign emit_last  = (ec_q == KW'(k_cl - 1'b1)) && (ew_q == WIW'(RW - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_op == OP_RUN) begin
          state_d = (limit_q == '0) ? ST_EMIT : ST_ASSIGN;
        end
      end
      ST_ASSIGN: begin
        if (!issue || issue_last) state_d = ST_ADRAIN;
      end
      ST_ADRAIN: begin
        if (drained) state_d = ST_VOTE;
      end
      ST_VOTE: begin
        if (!issue || issue_last) state_d = ST_VDRAIN;
      end
      ST_VDRAIN: begin
        if (drained) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!any_chg || 8'(round_q + 8'd1) == limit_q) state_d = ST_EMIT;
        else state_d = ST_ASSIGN;
      end
      ST_EMIT: begin
        if (out_load && emit_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = state_q == ST_IDLE;
    issue         = (state_q == ST_ASSIGN || state_q == ST_VOTE) && (pt_q != n_pts);
    run_start     = in_acc && in_op == OP_RUN;
    cmd.clr       = run_start;
    cmd.upd       = state_q == ST_UPDATE;
    out_load      = state_q == ST_EMIT && (!m_axis_tvalid || m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pt_q      <= '0;
      wd_q      <= '0;
      drn_q     <= '0;
      round_q   <= '0;
      lab_ptr_q <= '0;
      ec_q      <= '0;
      ew_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q != ST_ASSIGN && state_q != ST_VOTE) begin
        pt_q <= '0;
        wd_q <= '0;
      end else if (issue) begin
        wd_q <= wd_last ? '0 : wd_q + 1'b1;
        if (wd_last) pt_q <= pt_q + 1'b1;
      end
      drn_q <= (state_q == ST_ADRAIN || state_q == ST_VDRAIN) ? drn_q + 1'b1 : '0;
      if (run_start) round_q <= '0;
      else if (state_q == ST_UPDATE) round_q <= round_q + 8'd1;
      if (state_q == ST_IDLE || state_q == ST_UPDATE) lab_ptr_q <= '0;
      else if (lab_we) lab_ptr_q <= lab_ptr_q + 1'b1;
      if (state_q != ST_EMIT) begin
        ec_q <= '0;
        ew_q <= '0;
      end else if (out_load) begin
        ew_q <= (ew_q == WIW'(RW - 1)) ? '0 : ew_q + 1'b1;
        if (ew_q == WIW'(RW - 1)) ec_q <= ec_q + 1'b1;
      end
    end
  end

  // Descriptor and label memories with registered reads.
  logic [WORD_BITS-1:0] desc_mem [MAX_POINTS << WIW];
  logic [KW-1:0]        lab_mem  [MAX_POINTS];
  logic [WORD_BITS-1:0] rd_data_q;
  logic [KW-1:0]        rd_lab_q;
  logic [WIW-1:0]       rd_widx_q;
  beat_ctl_t            rd_ctl_q;
  logic                 desc_we;

  assign desc_we = in_acc && in_op == OP_LOAD_DESC && 32'(in_row) < MAX_POINTS && word_ok;

  always_ff @(posedge clk_i) begin
    if (desc_we) begin
      desc_mem[{PW'(in_row), WIW'(in_word)}] <= in_value;
    end
    rd_data_q <= desc_mem[AW'({pt_q[PW-1:0], wd_q})];
    rd_lab_q  <= lab_mem[pt_q[PW-1:0]];
    rd_widx_q <= wd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ctl_q <= '0;
    end else begin
      rd_ctl_q.vld  <= issue;
      rd_ctl_q.vote <= state_q == ST_VOTE;
      rd_ctl_q.last <= wd_last;
    end
  end

  // Cell chain: beat data moves one cell per cycle.
  beat_ctl_t            ch_ctl  [MAX_CLUSTERS+1];
  logic [WIW-1:0]       ch_widx [MAX_CLUSTERS+1];
  logic [WORD_BITS-1:0] ch_data [MAX_CLUSTERS+1];
  logic [KW-1:0]        ch_lab  [MAX_CLUSTERS+1];
  logic [DW-1:0]        ch_bd   [MAX_CLUSTERS+1];
  logic [KW-1:0]        ch_bi   [MAX_CLUSTERS+1];
  logic [MAX_CLUSTERS-1:0] chg;
  logic [RW*WORD_BITS-1:0] cen [MAX_CLUSTERS];

  assign ch_ctl[0]  = rd_ctl_q;
  assign ch_widx[0] = rd_widx_q;
  assign ch_data[0] = rd_data_q;
  assign ch_lab[0]  = rd_lab_q;
  assign ch_bd[0]   = '1;
  assign ch_bi[0]   = '0;

  for (genvar c = 0; c < MAX_CLUSTERS; c++) begin : g_cell
    logic en, ld_we;
    assign en    = c < k_cl;
    assign ld_we = in_acc && in_op == OP_LOAD_CENTER && 32'(in_row) == c && word_ok;
    bdkm_cell #(
      .IDX(c), .KW(KW), .RW(RW), .WIW(WIW), .DW(DW), .CNTW(CNTW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .cmd_i     (cmd),
      .ld_we_i   (ld_we),
      .ld_widx_i (WIW'(in_word)),
      .ld_data_i (in_value),
      .ctl_i     (ch_ctl[c]),
      .widx_i    (ch_widx[c]),
      .data_i    (ch_data[c]),
      .lab_i     (ch_lab[c]),
      .bd_i      (ch_bd[c]),
      .bi_i      (ch_bi[c]),
      .ctl_o     (ch_ctl[c+1]),
      .widx_o    (ch_widx[c+1]),
      .data_o    (ch_data[c+1]),
      .lab_o     (ch_lab[c+1]),
      .bd_o      (ch_bd[c+1]),
      .bi_o      (ch_bi[c+1]),
      .changed_o (chg[c]),
      .center_o  (cen[c])
    );
  end

  assign any_chg = |chg;

  // The final word of each point leaving the chain carries its label.
  assign lab_we = ch_ctl[MAX_CLUSTERS].vld && !ch_ctl[MAX_CLUSTERS].vote &&
                  ch_ctl[MAX_CLUSTERS].last;

  always_ff @(posedge clk_i) begin
    if (lab_we) lab_mem[lab_ptr_q] <= ch_bi[MAX_CLUSTERS];
  end

  // Output register.
  logic [WORD_BITS-1:0] out_word;
  assign out_word = cen[ec_q][ew_q*WORD_BITS +: WORD_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_axis_tdata <= {2'b00, round_q, out_word, 2'(ew_q), 4'(ec_q)};
      m_axis_tlast <= emit_last;
    end
  end

  // Labels are written only while an assignment pass is in flight.
  `BDKM_NEVER(a_lab_we_state, clk_i, rst_ni,
              lab_we && !(state_q == ST_ASSIGN || state_q == ST_ADRAIN))
  // The drain must flush assignment beats before voting starts.
  `BDKM_NEVER(a_vote_drained, clk_i, rst_ni,
              state_q == ST_VOTE && ch_ctl[MAX_CLUSTERS].vld && !ch_ctl[MAX_CLUSTERS].vote)
  // The chain is empty when the centers are updated.
  `BDKM_NEVER(a_update_empty, clk_i, rst_ni,
              state_q == ST_UPDATE && ch_ctl[MAX_CLUSTERS].vld)
  // A new output beat is loaded only during emission.
  `BDKM_ASSERT(a_out_from_emit, clk_i, rst_ni,
               $rose(m_axis_tvalid) |-> $past(state_q) == ST_EMIT)

endmodule

// ----- src/bdkm_cell.sv -----
// ----------------------------------------------------------------------------
// bdkm_cell
// One cluster center: distance accumulation, voting and majority update.
// ----------------------------------------------------------------------------
module bdkm_cell
  import bdkm_pkg::*;
#(
  parameter int unsigned IDX  = 0,
  parameter int unsigned KW   = 4,
  parameter int unsigned RW   = 4,
  parameter int unsigned WIW  = 2,
  parameter int unsigned DW   = 9,
  parameter int unsigned CNTW = 11
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  cell_cmd_t                  cmd_i,
  input  logic                       ld_we_i,
  input  logic [WIW-1:0]             ld_widx_i,
  input  logic [WORD_BITS-1:0]       ld_data_i,
  input  beat_ctl_t                  ctl_i,
  input  logic [WIW-1:0]             widx_i,
  input  logic [WORD_BITS-1:0]       data_i,
  input  logic [KW-1:0]              lab_i,
  input  logic [DW-1:0]              bd_i,
  input  logic [KW-1:0]              bi_i,
  output beat_ctl_t                  ctl_o,
  output logic [WIW-1:0]             widx_o,
  output logic [WORD_BITS-1:0]       data_o,
  output logic [KW-1:0]              lab_o,
  output logic [DW-1:0]              bd_o,
  output logic [KW-1:0]              bi_o,
  output logic                       changed_o,
  output logic [RW*WORD_BITS-1:0]    center_o
);

  logic [RW-1:0][WORD_BITS-1:0] center_q, center_nx;
  logic [CNTW-1:0]              votes_q [RW][WORD_BITS];
  logic [CNTW-1:0]              size_q;
  logic [DW-1:0]                acc_q, hdist;
  logic                         mine, take;

  assign hdist = (widx_i == '0 ? '0 : acc_q) +
                 DW'(popcnt64(data_i ^ center_q[widx_i]));
  assign mine = ctl_i.vld && ctl_i.vote && (lab_i == KW'(IDX));
  // This center becomes the best so far on the final word of a point.
  assign take = ctl_i.vld && !ctl_i.vote && ctl_i.last && en_i && (hdist < bd_i);

  always_comb begin
    for (int w = 0; w < RW; w++) begin
      for (int b = 0; b < WORD_BITS; b++) begin
        center_nx[w][b] = votes_q[w][b] > (size_q >> 1);
      end
    end
  end

  assign changed_o = en_i && (center_nx != center_q);
  assign center_o  = center_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    widx_o <= widx_i;
    data_o <= data_i;
    lab_o  <= lab_i;
    bd_o   <= take ? hdist : bd_i;
    bi_o   <= take ? KW'(IDX) : bi_i;
    if (ctl_i.vld && !ctl_i.vote) begin
      acc_q <= hdist;
    end
    if (ld_we_i) begin
      center_q[ld_widx_i] <= ld_data_i;
    end else if (cmd_i.upd && en_i) begin
      center_q <= center_nx;
    end
    if (cmd_i.clr || cmd_i.upd) begin
      size_q <= '0;
      for (int w = 0; w < RW; w++) begin
        for (int b = 0; b < WORD_BITS; b++) begin
          votes_q[w][b] <= '0;
        end
      end
    end else if (mine) begin
      if (widx_i == '0) begin
        size_q <= size_q + 1'b1;
      end
      for (int w = 0; w < RW; w++) begin
        if (widx_i == WIW'(w)) begin
          for (int b = 0; b < WORD_BITS; b++) begin
            votes_q[w][b] <= votes_q[w][b] + CNTW'(data_i[b]);
          end
        end
      end
    end
  end

endmodule
